// ===== hw/rtl/ssd_anchor_box_decode_assert.svh =====
// ----------------------------------------------------------------------------
// SSD anchor box decode assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SSD_ANCHOR_BOX_DECODE_ASSERT_SVH
`define SSD_ANCHOR_BOX_DECODE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SSDAB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssdab assertion failed");
// next-cycle implication
`define SSDAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssdab assertion failed");
`else
`define SSDAB_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SSDAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/ssdab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSD anchor box decode package
// Payload types, sequencer controls and saturation helper.
// ----------------------------------------------------------------------------
package ssdab_pkg;

  localparam int unsigned OpAW   = 34;
  localparam int unsigned OpBW   = 26;
  localparam int unsigned ProdW  = OpAW + OpBW;
  localparam int unsigned ScaleW = 34;

  localparam logic [2:0] PairCenter = 3'd0;
  localparam logic [2:0] PairSize   = 3'd1;

  localparam logic KindBox      = 1'b0;
  localparam logic KindKeypoint = 1'b1;

  localparam logic [1:0] CfgInvX  = 2'd0;
  localparam logic [1:0] CfgInvY  = 2'd1;
  localparam logic [1:0] CfgClip  = 2'd2;
  localparam logic [1:0] CfgKeep  = 2'd3;

  localparam logic [24:0]        InvScaleRst  = 25'd87381;
  localparam logic [30:0]        ScoreClipRst = 31'd6553600;
  localparam logic signed [31:0] KeepLogitRst = -32'sd26573;

  typedef struct packed {
    logic [2:0]         pair_index;
    logic signed [31:0] raw_a;
    logic signed [31:0] raw_b;
    logic signed [31:0] raw_score;
    logic [16:0]        anchor_x;
    logic [16:0]        anchor_y;
    logic [16:0]        anchor_w;
    logic [16:0]        anchor_h;
    logic               final_box;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] coord_a;
    logic signed [31:0] coord_b;
    logic signed [31:0] coord_c;
    logic signed [31:0] coord_d;
    logic signed [31:0] clipped_score;
    logic               keep;
    logic               box_done;
    logic               frame_end;
  } out_item_t;

  typedef struct packed {
    logic       accept;
    logic       mul_en;
    logic [1:0] step;
    logic       fin_go;
  } ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ssdab_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SSD anchor box decode shared multiplier
// Signed multiply with the product registered; used for every scale step.
// ----------------------------------------------------------------------------
module ssdab_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [ssdab_pkg::OpAW-1:0]    op_a,
  input  logic signed [ssdab_pkg::OpBW-1:0]    op_b,
  output logic signed [ssdab_pkg::ProdW-1:0]   prod_r
);
  import ssdab_pkg::*;

  logic signed [ProdW-1:0] prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ===== hw/rtl/ssdab_ctrl.sv =====
`timescale 1ns / 1ps
`include "ssd_anchor_box_decode_assert.svh"
// ----------------------------------------------------------------------------
// SSD anchor box decode sequencer
// Steps the shared multiplier four times per request, then retires it.
// ----------------------------------------------------------------------------
module ssdab_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             need_out,
  input  logic             out_free,
  output ssdab_pkg::ctrl_t ctrl
);
  import ssdab_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic       fin_go;

  assign in_ready = (state_r == ST_IDLE);
  assign fin_go   = (state_r == ST_FIN) && (!need_out || out_free);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL;
          step_nxt  = 2'd0;
        end
      end
      ST_MUL: begin
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign ctrl.accept = in_valid && in_ready;
  assign ctrl.mul_en = (state_r == ST_MUL);
  assign ctrl.step   = step_r;
  assign ctrl.fin_go = fin_go;

  `SSDAB_ASSERT_NXT(a_accept_starts, clk, rst_n, ctrl.accept, state_r == ST_MUL && step_r == 2'd0)
  `SSDAB_ASSERT_NXT(a_mul_to_fin, clk, rst_n, state_r == ST_MUL && step_r == 2'd3, state_r == ST_FIN)
  `SSDAB_ASSERT_NXT(a_fin_stall, clk, rst_n, state_r == ST_FIN && !fin_go, state_r == ST_FIN)
  `SSDAB_ASSERT_NOW(a_go_has_room, clk, rst_n, fin_go && need_out, out_free)

endmodule

// ===== hw/rtl/ssd_anchor_box_decode.sv =====
`timescale 1ns / 1ps
// An accepted pair runs four passes of the single shared multiplier, then the
// finish state; a new pair is accepted only when idle. A full output register
// stalls the finish of a pair that has a result. Reset is synchronous, active
// low: it clears the sequencer and output valid, zeroes the held centre and
// restores registers.
// ----------------------------------------------------------------------------
// SSD anchor box decode top level
// Decodes centre, size and keypoint pairs against anchors into box and keypoint records.
// ----------------------------------------------------------------------------
module ssd_anchor_box_decode #(
  parameter int unsigned KEYPOINT_PAIRS = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ssdab_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ssdab_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import ssdab_pkg::*;

  localparam int unsigned LastPair = KEYPOINT_PAIRS + 1;

  ctrl_t ctrl;

  logic [24:0]        inv_x_r, inv_y_r;
  logic [30:0]        clip_r;
  logic signed [31:0] keep_logit_r;
  logic signed [31:0] held_x_r, held_y_r;
  in_item_t           item_r;
  logic signed [ScaleW-1:0] va_r;
  out_item_t          out_r;
  logic               out_valid_r;

  logic signed [OpAW-1:0]   op_a;
  logic signed [OpBW-1:0]   op_b;
  logic signed [ProdW-1:0]  prod_r;
  logic [24:0]              inv_a, inv_b;
  logic signed [32:0]       p_shift;
  logic signed [ScaleW-1:0] vb;
  logic                     is_size, is_last, past_last, need_out, out_free;
  logic signed [34:0]       sum_x, sum_y, ymin, xmin, ymax, xmax;
  logic signed [32:0]       hw, hh;
  logic signed [31:0]       clip_pos, clip_neg, score_c;
  out_item_t                res;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_x_r      <= InvScaleRst;
      inv_y_r      <= InvScaleRst;
      clip_r       <= ScoreClipRst;
      keep_logit_r <= KeepLogitRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgInvX: inv_x_r      <= cfg_data[24:0];
        CfgInvY: inv_y_r      <= cfg_data[24:0];
        CfgClip: clip_r       <= cfg_data[30:0];
        CfgKeep: keep_logit_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  ssdab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .need_out (need_out),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      item_r <= in_data;
    end
  end

  assign is_size   = (item_r.pair_index == PairSize);
  assign is_last   = ({2'b00, item_r.pair_index} == 5'(LastPair));
  assign past_last = ({2'b00, item_r.pair_index} > 5'(LastPair));
  assign need_out  = (item_r.pair_index != PairCenter) && !past_last;
  assign out_free  = !out_valid_r || out_ready;

  // size pair swaps the scales, as width uses the height reciprocal
  assign inv_a   = is_size ? inv_y_r : inv_x_r;
  assign inv_b   = is_size ? inv_x_r : inv_y_r;
  assign p_shift = prod_r[56:24];

  always_comb begin
    case (ctrl.step)
      2'd0: begin
        op_a = OpAW'(item_r.raw_a);
        op_b = $signed({1'b0, inv_a});
      end
      2'd1: begin
        op_a = OpAW'(p_shift);
        op_b = $signed({9'b0, item_r.anchor_w});
      end
      2'd2: begin
        op_a = OpAW'(item_r.raw_b);
        op_b = $signed({1'b0, inv_b});
      end
      default: begin
        op_a = OpAW'(p_shift);
        op_b = $signed({9'b0, item_r.anchor_h});
      end
    endcase
  end

  ssdab_mul u_mul (
    .clk    (clk),
    .en     (ctrl.mul_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  always_ff @(posedge clk) begin
    if (ctrl.mul_en && ctrl.step == 2'd2) begin
      va_r <= prod_r[49:16];
    end
  end

  assign vb = prod_r[49:16];

  // finish
  assign sum_x = 35'(va_r) + $signed({18'b0, item_r.anchor_x});
  assign sum_y = 35'(vb) + $signed({18'b0, item_r.anchor_y});
  assign hw    = va_r[ScaleW-1:1];
  assign hh    = vb[ScaleW-1:1];
  assign ymin  = 35'(held_y_r) - 35'(hh);
  assign xmin  = 35'(held_x_r) - 35'(hw);
  assign ymax  = 35'(held_y_r) + 35'(hh);
  assign xmax  = 35'(held_x_r) + 35'(hw);

  assign clip_pos = $signed({1'b0, clip_r});
  assign clip_neg = -clip_pos;

  always_comb begin
    if (item_r.raw_score < clip_neg) begin
      score_c = clip_neg;
    end else if (item_r.raw_score > clip_pos) begin
      score_c = clip_pos;
    end else begin
      score_c = item_r.raw_score;
    end
  end

  always_comb begin
    res.box_done  = is_last;
    res.frame_end = is_last && item_r.final_box;
    if (is_size) begin
      res.result_kind   = KindBox;
      res.coord_a       = sat32(ymin);
      res.coord_b       = sat32(xmin);
      res.coord_c       = sat32(ymax);
      res.coord_d       = sat32(xmax);
      res.clipped_score = score_c;
      res.keep          = (score_c >= keep_logit_r) && !va_r[ScaleW-1] && !vb[ScaleW-1];
    end else begin
      res.result_kind   = KindKeypoint;
      res.coord_a       = sat32(sum_x);
      res.coord_b       = sat32(sum_y);
      res.coord_c       = '0;
      res.coord_d       = '0;
      res.clipped_score = '0;
      res.keep          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r <= '0;
      held_y_r <= '0;
    end else if (ctrl.fin_go && item_r.pair_index == PairCenter) begin
      held_x_r <= sat32(sum_x);
      held_y_r <= sat32(sum_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.fin_go && need_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin_go && need_out) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
